FILE: rtl/bpu_pkg.sv
package bpu_pkg;

  localparam int WORD_W       = 32;
  localparam int CHAN_W       = 8;
  localparam int SH_W         = $clog2(WORD_W);
  localparam int NUM_CHAN     = 4;
  localparam int FIELD_STAGES = 3;
  localparam int DIV_STEPS    = WORD_W;
  localparam int PIPE_DEPTH   = FIELD_STAGES + DIV_STEPS;
  localparam int IDX_W        = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_PIXEL_MODE = 3'd0,
    REG_RED_SEL    = 3'd1,
    REG_GREEN_SEL  = 3'd2,
    REG_BLUE_SEL   = 3'd3,
    REG_ALPHA_SEL  = 3'd4
  } cfg_reg_t;

  localparam logic MODE_BGR24  = 1'b0;
  localparam logic MODE_MASKED = 1'b1;

  localparam logic [WORD_W-1:0] RED_SEL_RST   = 32'h00ff_0000;
  localparam logic [WORD_W-1:0] GREEN_SEL_RST = 32'h0000_ff00;
  localparam logic [WORD_W-1:0] BLUE_SEL_RST  = 32'h0000_00ff;
  localparam logic [WORD_W-1:0] ALPHA_SEL_RST = 32'h0000_0000;
  localparam logic [CHAN_W-1:0] CHAN_FULL     = 8'hff;
  localparam logic [CHAN_W-1:0] CHAN_ZERO     = 8'h00;

  typedef struct packed {
    logic [WORD_W-1:0] num;
    logic [WORD_W-1:0] top;
  } div_req_t;

endpackage

FILE: rtl/bpu_field.sv
module bpu_field
  import bpu_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [WORD_W-1:0] word_i,
  input  logic [WORD_W-1:0] mask_i,
  input  logic              mode_i,
  input  logic [CHAN_W-1:0] byte_i,
  input  logic [CHAN_W-1:0] zero_i,
  output div_req_t          req_o
);

  logic [WORD_W-1:0] low_bit;
  logic [SH_W-1:0]   sh;
  logic              byp;
  logic [CHAN_W-1:0] byp_val;

  logic [WORD_W-1:0] wm_r;
  logic [WORD_W-1:0] mask_r;
  logic [SH_W-1:0]   sh_r;
  logic              byp1_r;
  logic [CHAN_W-1:0] val1_r;

  logic [WORD_W-1:0] field_r;
  logic [WORD_W-1:0] top_r;
  logic              byp2_r;
  logic [CHAN_W-1:0] val2_r;

  logic [WORD_W-1:0] num;
  div_req_t          req_nxt;
  div_req_t          req_r;

  // isolate lowest set bit, then encode the one-hot position
  always_comb begin
    low_bit = mask_i & (~mask_i + WORD_W'(1));
    sh      = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (low_bit[i]) begin
        sh = sh | SH_W'(i);
      end
    end
    byp     = (mode_i == MODE_BGR24) || (mask_i == '0);
    byp_val = (mode_i == MODE_MASKED) ? zero_i : byte_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wm_r   <= word_i & mask_i;
      mask_r <= mask_i;
      sh_r   <= sh;
      byp1_r <= byp;
      val1_r <= byp_val;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      field_r <= wm_r >> sh_r;
      top_r   <= mask_r >> sh_r;
      byp2_r  <= byp1_r;
      val2_r  <= val1_r;
    end
  end

  // value*255 + top/2, wrapped to the word width; a bypass passes the byte over 1
  always_comb begin
    num = {field_r[WORD_W-CHAN_W-1:0], CHAN_W'(0)} - field_r + (top_r >> 1);
    if (byp2_r) begin
      req_nxt.num = WORD_W'(val2_r);
      req_nxt.top = WORD_W'(1);
    end else begin
      req_nxt.num = num;
      req_nxt.top = top_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req_r <= req_nxt;
    end
  end

  assign req_o = req_r;

endmodule

FILE: rtl/bpu_div.sv
module bpu_div
  import bpu_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  div_req_t          req_i,
  output logic [CHAN_W-1:0] quot_o
);

  logic [WORD_W-1:0] rem_r [DIV_STEPS];
  logic [WORD_W-1:0] num_r [DIV_STEPS];
  logic [WORD_W-1:0] top_r [DIV_STEPS];
  logic [CHAN_W-1:0] quo_r [DIV_STEPS];

  // one restoring step per stage, keep only the low quotient bits
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [WORD_W-1:0] rem_in;
    logic [WORD_W-1:0] num_in;
    logic [WORD_W-1:0] top_in;
    logic [CHAN_W-1:0] quo_in;
    logic [WORD_W:0]   part;
    logic [WORD_W:0]   diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = req_i.num;
      assign top_in = req_i.top;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign num_in = num_r[s-1];
      assign top_in = top_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    always_comb begin
      part = {rem_in, num_in[WORD_W-1]};
      diff = part - {1'b0, top_in};
      ge   = !diff[WORD_W];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? diff[WORD_W-1:0] : part[WORD_W-1:0];
        num_r[s] <= {num_in[WORD_W-2:0], 1'b0};
        top_r[s] <= top_in;
        quo_r[s] <= {quo_in[CHAN_W-2:0], ge};
      end
    end
  end

  assign quot_o = quo_r[DIV_STEPS-1];

endmodule

FILE: rtl/bitfield_pixel_unpack_top.sv
// An input transfer reaches out_tvalid through three field-extract stages,
// a 32-stage one-bit-per-stage divider and the output register.
// Throughput: one pixel per cycle while the skid entry is empty; a two-entry
// output register and skid buffer lets the pipeline run while a result waits.
// Reset (rst_n low, synchronous): pipeline emptied, masks and mode to defaults.
module bitfield_pixel_unpack_top
  import bpu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // [31:0] pixel_word
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // [7:0] blue_value, [15:8] green_value,
                                        // [23:16] red_value, [31:24] alpha_value
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0] cfg_data
);

  logic              mode_r;
  logic [WORD_W-1:0] red_sel_r;
  logic [WORD_W-1:0] green_sel_r;
  logic [WORD_W-1:0] blue_sel_r;
  logic [WORD_W-1:0] alpha_sel_r;

  logic              en;
  logic [PIPE_DEPTH-1:0] vld_r;

  logic [WORD_W-1:0] lane_mask [NUM_CHAN];
  logic [CHAN_W-1:0] lane_byte [NUM_CHAN];
  logic [CHAN_W-1:0] lane_zero [NUM_CHAN];
  logic [CHAN_W-1:0] lane_quot [NUM_CHAN];
  logic [WORD_W-1:0] pipe_data;

  logic              out_vld_r;
  logic [WORD_W-1:0] out_data_r;
  logic              skid_vld_r;
  logic [WORD_W-1:0] skid_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_MASKED;
      red_sel_r   <= RED_SEL_RST;
      green_sel_r <= GREEN_SEL_RST;
      blue_sel_r  <= BLUE_SEL_RST;
      alpha_sel_r <= ALPHA_SEL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PIXEL_MODE: mode_r      <= cfg_data[0];
        REG_RED_SEL:    red_sel_r   <= cfg_data;
        REG_GREEN_SEL:  green_sel_r <= cfg_data;
        REG_BLUE_SEL:   blue_sel_r  <= cfg_data;
        REG_ALPHA_SEL:  alpha_sel_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // freeze the whole pipeline while the skid entry is occupied
  assign en        = !skid_vld_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  always_comb begin
    lane_mask[0] = blue_sel_r;
    lane_mask[1] = green_sel_r;
    lane_mask[2] = red_sel_r;
    lane_mask[3] = alpha_sel_r;
    lane_byte[0] = in_tdata[7:0];
    lane_byte[1] = in_tdata[15:8];
    lane_byte[2] = in_tdata[23:16];
    lane_byte[3] = CHAN_FULL;
    lane_zero[0] = CHAN_ZERO;
    lane_zero[1] = CHAN_ZERO;
    lane_zero[2] = CHAN_ZERO;
    lane_zero[3] = CHAN_FULL;
  end

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    div_req_t req;

    bpu_field u_field (
      .clk    (clk),
      .en     (en),
      .word_i (in_tdata),
      .mask_i (lane_mask[c]),
      .mode_i (mode_r),
      .byte_i (lane_byte[c]),
      .zero_i (lane_zero[c]),
      .req_o  (req)
    );

    bpu_div u_div (
      .clk    (clk),
      .en     (en),
      .req_i  (req),
      .quot_o (lane_quot[c])
    );

    assign pipe_data[c*CHAN_W +: CHAN_W] = lane_quot[c];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_tready) begin
        skid_vld_r <= 1'b0;
      end
    end else if (out_vld_r && !out_tready) begin
      skid_vld_r <= vld_r[PIPE_DEPTH-1];
    end else begin
      out_vld_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_tready) begin
        out_data_r <= skid_data_r;
      end
    end else if (out_vld_r && !out_tready) begin
      skid_data_r <= pipe_data;
    end else begin
      out_data_r <= pipe_data;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
